// File: src/rv32s_pkg.sv
// shared types and encoding constants for the rv32i subset core
package rv32s_pkg;

    localparam int XLEN = 32;
    localparam int REG_COUNT = 32;
    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int MADDR_W = 12;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;

    localparam logic [2:0] F3_XOR = 3'b100;
    localparam logic [2:0] F3_SRA = 3'b101;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    typedef logic [XLEN-1:0] t_word;

    typedef struct packed {
        logic [XLEN-1:0]        exec_pc;
        logic [XLEN-1:0]        next_pc;
        logic                   reg_write;
        logic [RIDX_W-1:0]      reg_dest;
        logic signed [XLEN-1:0] reg_value;
        logic                   mem_write;
        logic [MADDR_W-1:0]     mem_addr;
        logic signed [XLEN-1:0] mem_data;
        logic                   branch_taken;
        logic                   illegal;
    } t_result;

endpackage

// File: src/rv32s_stream_if.sv
// valid/ready stream channel with a typed payload
interface rv32s_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/rv32i_subset_single_cycle_core_top.sv
// rv32i subset core: two-stage execute around a register file and a data store
//
//  channel    dir  payload              transfer when
//  i_instr    in   instruction word     i_instr.valid && i_instr.ready
//  o_result   out  rv32s_pkg::t_result  o_result.valid && o_result.ready
//
// one instruction per cycle sustained while o_result is ready and no sweep runs; a result is valid in
// the result register (operands registered at the transfer, then execute and data store access)
// after reset the data store is swept to zero, every word, with i_instr.ready low during the sweep
// a stall on o_result holds both stages; an instruction is still taken while stage one is free
// operands are forwarded from the result stage, including load data from the data store port
module rv32i_subset_single_cycle_core_top #(
    parameter int DATA_WORDS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rv32s_stream_if.sink   i_instr,
    rv32s_stream_if.source o_result
);
    import rv32s_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    // data store sweep after reset
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // stage one: operands read from the register file
    logic              r_v1;
    t_word             r1_instr;
    t_word             r_pc;
    t_word             r_rs1_q;
    t_word             r_rs2_q;

    // stage two: result register
    logic               r_v2;
    t_word              r2_exec_pc;
    t_word              r2_next_pc;
    logic               r2_reg_write;
    logic [RIDX_W-1:0]  r2_reg_dest;
    t_word              r2_alu_val;
    logic               r2_is_load;
    logic               r2_mem_write;
    logic [MADDR_W-1:0] r2_mem_addr;
    t_word              r2_store_data;
    logic               r2_taken;
    logic               r2_illegal;

    // storage
    t_word           r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_valid;
    t_word           r_dmem [DATA_WORDS];
    t_word           r_dmem_q;

    logic in_xfer;
    logic out_xfer;
    logic s1_adv;

    // stage one decode and execute
    logic [6:0]        opc;
    logic [RIDX_W-1:0] rd;
    logic [RIDX_W-1:0] rs1;
    logic [RIDX_W-1:0] rs2;
    logic [2:0]        f3;
    t_word             imm_i;
    t_word             imm_s;
    t_word             imm_b;
    t_word             s2_fwd_val;
    t_word             op_a;
    t_word             op_b;
    t_word             alu_b;
    t_word             sum_b;
    t_word             alu_sum;
    t_word             alu_val;
    t_word             agen;
    t_word             pc_plus4;
    logic              is_sub;
    logic              lt;
    logic [AW-1:0]     dmem_idx;
    t_word             dmem_idx_ext;

    t_word              n_next_pc;
    logic               n_wr;
    t_word              n_alu_val;
    logic               n_is_load;
    logic               n_mem_write;
    logic               n_taken;
    logic               n_illegal;

    // register file write port and read addresses
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [RIDX_W-1:0] rf_ra1;
    logic [RIDX_W-1:0] rf_ra2;

    // data store port
    logic          dmem_we;
    logic [AW-1:0] dmem_waddr;
    t_word         dmem_wdata;
    logic          dmem_re;

    t_result result;

    assign out_xfer = r_v2 && o_result.ready;
    assign s1_adv   = r_v1 && (!r_v2 || o_result.ready);
    assign i_instr.ready = !r_clr_busy && (!r_v1 || s1_adv);
    assign in_xfer  = i_instr.valid && i_instr.ready;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_pc       <= '0;
            r_rf_valid <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DATA_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_xfer) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_v2 <= 1'b1;
                r_pc <= n_next_pc;
            end else if (out_xfer) begin
                r_v2 <= 1'b0;
            end
            if (rf_we) begin
                r_rf_valid[rf_waddr] <= 1'b1;
            end
        end
    end

    // ---------------- register file ----------------
    assign rf_we    = out_xfer && r2_reg_write;
    assign rf_waddr = r2_reg_dest;
    assign rf_ra1   = i_instr.payload[19:15];
    assign rf_ra2   = i_instr.payload[24:20];

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= s2_fwd_val;
        end
    end

    // read with write-through so a same-edge writeback is seen
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_instr <= i_instr.payload;
            if (rf_we && rf_waddr == rf_ra1) begin
                r_rs1_q <= s2_fwd_val;
            end else begin
                r_rs1_q <= r_rf_valid[rf_ra1] ? r_rf[rf_ra1] : '0;
            end
            if (rf_we && rf_waddr == rf_ra2) begin
                r_rs2_q <= s2_fwd_val;
            end else begin
                r_rs2_q <= r_rf_valid[rf_ra2] ? r_rf[rf_ra2] : '0;
            end
        end
    end

    // ---------------- stage one ----------------
    assign opc = r1_instr[6:0];
    assign rd  = r1_instr[11:7];
    assign f3  = r1_instr[14:12];
    assign rs1 = r1_instr[19:15];
    assign rs2 = r1_instr[24:20];

    assign imm_i = {{20{r1_instr[31]}}, r1_instr[31:20]};
    assign imm_s = {{20{r1_instr[31]}}, r1_instr[31:25], r1_instr[11:7]};
    assign imm_b = {{19{r1_instr[31]}}, r1_instr[31], r1_instr[7], r1_instr[30:25],
                    r1_instr[11:8], 1'b0};

    // the result stage holds the only writeback not yet in the register file
    assign s2_fwd_val = r2_is_load ? r_dmem_q : r2_alu_val;
    assign op_a = (r_v2 && r2_reg_write && r2_reg_dest == rs1) ? s2_fwd_val : r_rs1_q;
    assign op_b = (r_v2 && r2_reg_write && r2_reg_dest == rs2) ? s2_fwd_val : r_rs2_q;

    always_comb begin
        if (opc == OP_REG) begin
            alu_b = op_b;
        end else if (f3 == F3_SRA) begin
            alu_b = {27'b0, imm_i[4:0]};
        end else begin
            alu_b = imm_i;
        end
    end

    assign is_sub  = (opc == OP_REG) && r1_instr[30];
    assign sum_b   = is_sub ? ~alu_b : alu_b;
    assign alu_sum = op_a + sum_b + t_word'(is_sub);

    always_comb begin
        case (f3)
            F3_AND:  alu_val = op_a & alu_b;
            F3_OR:   alu_val = op_a | alu_b;
            F3_XOR:  alu_val = op_a ^ alu_b;
            F3_SRA:  alu_val = t_word'($signed(op_a) >>> alu_b[4:0]);
            default: alu_val = alu_sum;
        endcase
    end

    assign agen     = op_a + ((opc == OP_STORE) ? imm_s : imm_i);
    assign pc_plus4 = r_pc + 32'd4;
    assign lt       = $signed(op_a) < $signed(op_b);

    // word index modulo the store depth
    generate
        if ((DATA_WORDS & (DATA_WORDS - 1)) == 0) begin : g_mod_pow2
            assign dmem_idx = agen[AW-1:0];
        end else begin : g_mod_tab
            logic [AW-1:0] mod_tab [4][256];
            logic [AW+1:0] part_sum;
            logic [AW+1:0] red1;
            for (genvar k = 0; k < 4; k++) begin : g_byte
                for (genvar j = 0; j < 256; j++) begin : g_entry
                    assign mod_tab[k][j] = AW'((64'(j) << (8 * k)) % DATA_WORDS);
                end
            end
            assign part_sum = (AW+2)'(mod_tab[0][agen[7:0]]) + (AW+2)'(mod_tab[1][agen[15:8]])
                            + (AW+2)'(mod_tab[2][agen[23:16]])
                            + (AW+2)'(mod_tab[3][agen[31:24]]);
            // part_sum stays below four times the depth
            assign red1 = (part_sum >= (AW+2)'(2 * DATA_WORDS))
                        ? part_sum - (AW+2)'(2 * DATA_WORDS) : part_sum;
            assign dmem_idx = (red1 >= (AW+2)'(DATA_WORDS))
                            ? AW'(red1 - (AW+2)'(DATA_WORDS)) : AW'(red1);
        end
    endgenerate

    assign dmem_idx_ext = t_word'(dmem_idx);

    always_comb begin
        n_next_pc   = pc_plus4;
        n_wr        = 1'b0;
        n_alu_val   = alu_val;
        n_is_load   = 1'b0;
        n_mem_write = 1'b0;
        n_taken     = 1'b0;
        n_illegal   = 1'b0;
        case (opc)
            OP_REG, OP_IMM: begin
                n_wr = 1'b1;
            end
            OP_LOAD: begin
                n_wr      = 1'b1;
                n_is_load = 1'b1;
            end
            OP_STORE: begin
                n_mem_write = 1'b1;
            end
            OP_BRANCH: begin
                if (f3 == F3_XOR && lt) begin
                    n_taken   = 1'b1;
                    n_next_pc = r_pc + imm_b;
                end
            end
            OP_JALR: begin
                n_taken   = 1'b1;
                n_next_pc = {agen[31:1], 1'b0};
                n_wr      = 1'b1;
                n_alu_val = pc_plus4;
            end
            default: begin
                n_illegal = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r2_exec_pc    <= r_pc;
            r2_next_pc    <= n_next_pc;
            r2_reg_write  <= n_wr && (rd != '0);
            r2_reg_dest   <= (n_wr && (rd != '0)) ? rd : '0;
            r2_alu_val    <= n_alu_val;
            r2_is_load    <= n_is_load;
            r2_mem_write  <= n_mem_write;
            r2_mem_addr   <= (n_is_load || n_mem_write) ? dmem_idx_ext[MADDR_W-1:0] : '0;
            r2_store_data <= n_mem_write ? op_b : '0;
            r2_taken      <= n_taken;
            r2_illegal    <= n_illegal;
        end
    end

    // ---------------- data store ----------------
    assign dmem_we    = r_clr_busy || (s1_adv && n_mem_write);
    assign dmem_waddr = r_clr_busy ? r_clr_addr : dmem_idx;
    assign dmem_wdata = r_clr_busy ? '0 : op_b;
    assign dmem_re    = s1_adv && n_is_load;

    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[dmem_waddr] <= dmem_wdata;
        end
        if (dmem_re) begin
            r_dmem_q <= r_dmem[dmem_idx];
        end
    end

    // ---------------- result ----------------
    always_comb begin
        result.exec_pc      = r2_exec_pc;
        result.next_pc      = r2_next_pc;
        result.reg_write    = r2_reg_write;
        result.reg_dest     = r2_reg_dest;
        result.reg_value    = r2_reg_write ? s2_fwd_val : '0;
        result.mem_write    = r2_mem_write;
        result.mem_addr     = r2_mem_addr;
        result.mem_data     = r2_is_load ? r_dmem_q : r2_store_data;
        result.branch_taken = r2_taken;
        result.illegal      = r2_illegal;
    end

    assign o_result.valid   = r_v2;
    assign o_result.payload = result;

endmodule
